// ===== src/utt8_pkg.sv =====
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 transcoder.
package utt8_pkg;

  // Source formats held in the format register.
  localparam logic [1:0] FMT_U16LE = 2'd0;
  localparam logic [1:0] FMT_U16BE = 2'd1;
  localparam logic [1:0] FMT_U32LE = 2'd2;
  localparam logic [1:0] FMT_U32BE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Register byte-address selector (bit 2 of paddr).
  localparam logic REG_FORMAT = 1'b0;

  localparam int unsigned CP_WIDTH    = 21;
  localparam int unsigned EPOS_WIDTH  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_WIDTH-1:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [31:0]         CP_MAX       = 32'h0010FFFF;

  // One queued work unit: an optional code point and an optional closing status.
  typedef struct packed {
    logic                  cp_valid;
    logic [CP_WIDTH-1:0]   cp;
    logic                  status_valid;
    logic [1:0]            status;
    logic [EPOS_WIDTH-1:0] pos;
  } utt8_entry_t;

endpackage

// ===== src/utt8_front.sv =====
// Front end: gathers source bytes into code units, checks them, queues work.
module utt8_front #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           format_i,
  input  logic                 clear_i,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 push_o,
  output utt8_pkg::utt8_entry_t entry_o
);

  localparam logic [POS_WIDTH-1:0] PosMax = '1;

  logic [23:0]                   gather_q, gather_d;
  logic [1:0]                    phase_q, phase_d;
  logic                          hi_pend_q, hi_pend_d;
  logic [9:0]                    hi_bits_q, hi_bits_d;
  logic [POS_WIDTH-1:0]          count_q, count_d;
  logic                          err_q, err_d;
  logic [POS_WIDTH-1:0]          err_pos_q, err_pos_d;

  logic [POS_WIDTH-1:0]          unit_pos;
  logic [15:0]                   unit16;
  logic [31:0]                   word32;
  logic                          u_high, u_low;
  logic                          odd, flag;
  logic                          cp_valid;
  logic [utt8_pkg::CP_WIDTH-1:0] cp;
  logic [POS_WIDTH-1:0]          report_pos;
  logic [63:0]                   report_ext;

  assign unit_pos = count_q - POS_WIDTH'(phase_q);
  assign unit16   = format_i[0] ? {gather_q[7:0], in_byte_i} : {in_byte_i, gather_q[7:0]};
  assign word32   = format_i[0] ? {gather_q[7:0], gather_q[15:8], gather_q[23:16], in_byte_i}
                                : {in_byte_i, gather_q};
  assign u_high   = (unit16[15:10] == 6'b110110);
  assign u_low    = (unit16[15:10] == 6'b110111);

  always_comb begin
    gather_d  = gather_q;
    phase_d   = phase_q;
    hi_pend_d = hi_pend_q;
    hi_bits_d = hi_bits_q;
    count_d   = count_q;
    err_d     = err_q;
    err_pos_d = err_pos_q;
    odd       = 1'b0;
    flag      = 1'b0;
    cp_valid  = 1'b0;
    cp        = '0;
    if (accept_i) begin
      if (!format_i[1]) begin
        if (phase_q == 2'd0) begin
          gather_d = {16'd0, in_byte_i};
          phase_d  = 2'd1;
          odd      = 1'b1;
        end else begin
          gather_d = '0;
          phase_d  = 2'd0;
          if (!err_q) begin
            if (hi_pend_q) begin
              // Second half of a pair: must be a low surrogate.
              if (u_low) begin
                cp_valid = 1'b1;
                cp       = utt8_pkg::CP_SUPP_BASE + {1'b0, hi_bits_q, unit16[9:0]};
              end else begin
                flag = 1'b1;
              end
              hi_pend_d = 1'b0;
              hi_bits_d = '0;
            end else if (u_high) begin
              if (in_last_i) begin
                flag = 1'b1;
              end else begin
                hi_pend_d = 1'b1;
                hi_bits_d = unit16[9:0];
              end
            end else if (u_low) begin
              flag = 1'b1;
            end else begin
              cp_valid = 1'b1;
              cp       = {5'd0, unit16};
            end
          end
        end
      end else begin
        if (phase_q != 2'd3) begin
          gather_d = gather_q | (24'(in_byte_i) << {phase_q, 3'b000});
          phase_d  = phase_q + 2'd1;
        end else begin
          gather_d = '0;
          phase_d  = 2'd0;
          if (!err_q) begin
            if ((word32 > utt8_pkg::CP_MAX) || (word32[31:11] == 21'h1B)) begin
              flag = 1'b1;
            end else begin
              cp_valid = 1'b1;
              cp       = word32[utt8_pkg::CP_WIDTH-1:0];
            end
          end
        end
      end
      if (flag) begin
        err_d     = 1'b1;
        err_pos_d = unit_pos;
      end
      if (count_q != PosMax) begin
        count_d = count_q + POS_WIDTH'(1);
      end
      // Close the stream: drop all stream state.
      if (in_last_i) begin
        gather_d  = '0;
        phase_d   = 2'd0;
        hi_pend_d = 1'b0;
        hi_bits_d = '0;
        count_d   = '0;
        err_d     = 1'b0;
        err_pos_d = '0;
      end
    end
    if (clear_i) begin
      gather_d  = '0;
      phase_d   = 2'd0;
      hi_pend_d = 1'b0;
      hi_bits_d = '0;
      count_d   = '0;
      err_d     = 1'b0;
      err_pos_d = '0;
    end
  end

  // Odd length wins and is reported at the last byte.
  assign report_pos = odd ? count_q : (flag ? unit_pos : err_pos_q);
  assign report_ext = 64'(report_pos);

  always_comb begin
    entry_o.cp_valid     = cp_valid;
    entry_o.cp           = cp;
    entry_o.status_valid = in_last_i;
    entry_o.status       = utt8_pkg::ST_OK;
    entry_o.pos          = '0;
    if (odd || flag || err_q) begin
      entry_o.status = utt8_pkg::ST_BAD;
      entry_o.pos    = (report_ext[63:32] != 32'd0) ? '1 : report_ext[31:0];
    end
  end

  assign push_o = accept_i && (cp_valid || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q  <= '0;
      phase_q   <= 2'd0;
      hi_pend_q <= 1'b0;
      hi_bits_q <= '0;
      count_q   <= '0;
      err_q     <= 1'b0;
      err_pos_q <= '0;
    end else begin
      gather_q  <= gather_d;
      phase_q   <= phase_d;
      hi_pend_q <= hi_pend_d;
      hi_bits_q <= hi_bits_d;
      count_q   <= count_d;
      err_q     <= err_d;
      err_pos_q <= err_pos_d;
    end
  end

endmodule

// ===== src/utt8_queue.sv =====
// Short work queue between the front end and the byte emitter.
module utt8_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utt8_pkg::utt8_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  nonempty_o,
  output utt8_pkg::utt8_entry_t head_o
);

  localparam int unsigned PtrW = $clog2(utt8_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(utt8_pkg::QUEUE_DEPTH + 1);

  utt8_pkg::utt8_entry_t slots_q [utt8_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(utt8_pkg::QUEUE_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign head_o     = slots_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> (count_q == CntW'(utt8_pkg::QUEUE_DEPTH)) || $past(do_pop))
    else $error("queue count moved from full without a pop");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == CntW'(utt8_pkg::QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_o && !do_push && do_pop && count_q == CntW'(1)) |=> !nonempty_o)
    else $error("queue not empty after last pop");
`endif

endmodule

// ===== src/utt8_back.sv =====
// Back end: expands queued code points into UTF-8 bytes and closing status.
module utt8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  utt8_pkg::utt8_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            out_status_o,
  output logic                  out_last_o,
  output logic [31:0]           out_error_pos_o
);

  logic [2:0]  idx_q;
  logic [2:0]  ncp;
  logic [1:0]  rem;
  logic        is_byte, last_piece, load;
  logic [7:0]  byte_val;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic [1:0]  status_q;
  logic        last_q;
  logic [31:0] pos_q;

  always_comb begin
    if (head_i.cp < 21'h80) begin
      ncp = 3'd1;
    end else if (head_i.cp < 21'h800) begin
      ncp = 3'd2;
    end else if (head_i.cp < 21'h10000) begin
      ncp = 3'd3;
    end else begin
      ncp = 3'd4;
    end
  end

  assign is_byte    = head_i.cp_valid && (idx_q < ncp);
  assign rem        = 2'(ncp - 3'd1 - idx_q);
  assign last_piece = is_byte ? ((idx_q == ncp - 3'd1) && !head_i.status_valid) : 1'b1;
  assign load       = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o      = load && last_piece;

  always_comb begin
    if (idx_q == 3'd0) begin
      unique case (ncp)
        3'd1:    byte_val = {1'b0, head_i.cp[6:0]};
        3'd2:    byte_val = {3'b110, head_i.cp[10:6]};
        3'd3:    byte_val = {4'b1110, head_i.cp[15:12]};
        default: byte_val = {5'b11110, head_i.cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    byte_val = {2'b10, head_i.cp[5:0]};
        2'd1:    byte_val = {2'b10, head_i.cp[11:6]};
        default: byte_val = {2'b10, head_i.cp[17:12]};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_byte) begin
        byte_q   <= byte_val;
        status_q <= utt8_pkg::ST_DATA;
        last_q   <= 1'b0;
        pos_q    <= '0;
      end else begin
        byte_q   <= '0;
        status_q <= head_i.status;
        last_q   <= 1'b1;
        pos_q    <= head_i.pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_piece ? 3'd0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign out_status_o    = status_q;
  assign out_last_o      = last_q;
  assign out_error_pos_o = pos_q;

endmodule

// ===== src/utf16_utf32_to_utf8_unit.sv =====
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
// The first result of a source byte passes the work queue and the emitter's output register.
// Throughput: one source byte per cycle while the work queue has room; the
// emitter gives one result per cycle, one per UTF-8 byte, while the result channel does not stall.
// Reset clears the format register (UTF-16 LE), the stream state and the queue.
module utf16_utf32_to_utf8_unit #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // source byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // UTF-8 result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o,
  output logic [31:0] out_error_pos_o
);

  logic [1:0]            format_q;
  logic                  cfg_wr, fmt_wr;
  logic                  accept;
  logic                  push, pop, full, nonempty;
  utt8_pkg::utt8_entry_t entry, head;

  // Register write completes in the access phase; the low address bits
  // select a byte within the word and are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign fmt_wr = cfg_wr && (paddr[2] == utt8_pkg::REG_FORMAT);
  assign prdata = (paddr[2] == utt8_pkg::REG_FORMAT) ? {30'd0, format_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= utt8_pkg::FMT_U16LE;
    end else if (fmt_wr) begin
      format_q <= pwdata[1:0];
    end
  end

  // Hold the source side while the queue is full.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  utt8_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .format_i  (format_q),
    .clear_i   (fmt_wr),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (push),
    .entry_o   (entry)
  );

  utt8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (entry),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  // The emitter's output register parts the queue from the result channel.
  utt8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (nonempty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_status_o    (out_status_o),
    .out_last_o      (out_last_o),
    .out_error_pos_o (out_error_pos_o)
  );

`ifndef SYNTHESIS
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == utt8_pkg::ST_DATA)
      |-> !out_last_o && (out_error_pos_o == 32'd0))
    else $error("data result carries closing fields");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != utt8_pkg::ST_DATA) |-> out_last_o && (out_byte_o == 8'd0))
    else $error("status result without last or with a byte");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == utt8_pkg::ST_DATA) || (out_status_o == utt8_pkg::ST_OK)
      || (out_status_o == utt8_pkg::ST_BAD))
    else $error("undefined status code");
  a_ok_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == utt8_pkg::ST_OK) |-> out_error_pos_o == 32'd0)
    else $error("good stream reports an error position");
`endif

endmodule

// ===== bench/utf16_utf32_to_utf8_unit_tb.sv =====
// Self-checking testbench for the UTF-16/UTF-32 to UTF-8 transcoder unit.
module utf16_utf32_to_utf8_unit_tb;

  // One UTF-8 channel transaction as the sink sees it.
  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  status;
    logic        close;
    logic [31:0] err_pos;
  } utf8_result_t;

  // Tracks the transcoder's stream state and the UTF-8 results still owed.
  class transcode_tracker;
    utf8_result_t utf8_due[$];
    int          errors;
    logic [1:0]  fmt;
    logic [23:0] gather;
    logic [1:0]  phase;
    logic        hi_pend;
    logic [9:0]  hi_bits;
    logic [31:0] count;
    logic        err_seen;
    logic [31:0] err_pos;

    function new();
      errors = 0;
      fmt = utt8_pkg::FMT_U16LE;
      clear_stream();
    endfunction

    function void clear_stream();
      gather = '0;
      phase = '0;
      hi_pend = 1'b0;
      hi_bits = '0;
      count = '0;
      err_seen = 1'b0;
      err_pos = '0;
    endfunction

    // A format write also drops any stream in progress.
    function void set_format(logic [1:0] f);
      fmt = f;
      clear_stream();
    endfunction

    function void owe(logic [7:0] d, logic [1:0] st, logic cl, logic [31:0] p);
      utf8_result_t r;
      r.data = d;
      r.status = st;
      r.close = cl;
      r.err_pos = p;
      utf8_due.push_back(r);
    endfunction

    function void owe_code_point(logic [31:0] cp);
      if (cp < 32'h80) begin
        owe(cp[7:0], utt8_pkg::ST_DATA, 1'b0, '0);
      end else if (cp < 32'h800) begin
        owe({3'b110, cp[10:6]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[5:0]}, utt8_pkg::ST_DATA, 1'b0, '0);
      end else if (cp < 32'h10000) begin
        owe({4'b1110, cp[15:12]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[11:6]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[5:0]}, utt8_pkg::ST_DATA, 1'b0, '0);
      end else begin
        owe({5'b11110, cp[20:18]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[17:12]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[11:6]}, utt8_pkg::ST_DATA, 1'b0, '0);
        owe({2'b10, cp[5:0]}, utt8_pkg::ST_DATA, 1'b0, '0);
      end
    endfunction

    function void flag(logic [31:0] p);
      if (!err_seen) begin
        err_seen = 1'b1;
        err_pos = p;
      end
    endfunction

    // Advance the stream by one accepted source byte.
    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] pos;
      logic [31:0] unit_pos;
      logic [31:0] u;
      logic        odd;
      pos = count;
      unit_pos = pos - 32'(phase);
      odd = 1'b0;
      if (!fmt[1]) begin
        if (phase == 2'd0) begin
          gather = {16'h0, b};
          phase = 2'd1;
          odd = 1'b1;
        end else begin
          u = fmt[0] ? {16'h0, gather[7:0], b} : {16'h0, b, gather[7:0]};
          phase = 2'd0;
          gather = '0;
          if (!err_seen) begin
            if (hi_pend) begin
              if (u >= 32'hDC00 && u <= 32'hDFFF)
                owe_code_point(32'h10000 + {12'h0, hi_bits, 10'h0} + {22'h0, u[9:0]});
              else
                flag(unit_pos);
              hi_pend = 1'b0;
              hi_bits = '0;
            end else if (u >= 32'hD800 && u <= 32'hDBFF) begin
              if (last) begin
                flag(unit_pos);
              end else begin
                hi_pend = 1'b1;
                hi_bits = u[9:0];
              end
            end else if (u >= 32'hDC00 && u <= 32'hDFFF) begin
              flag(unit_pos);
            end else begin
              owe_code_point(u);
            end
          end
        end
      end else begin
        if (phase < 2'd3) begin
          gather[8*phase +: 8] = b;
          phase = phase + 2'd1;
        end else begin
          u = fmt[0] ? {gather[7:0], gather[15:8], gather[23:16], b} : {b, gather};
          phase = 2'd0;
          gather = '0;
          if (!err_seen) begin
            if (u > 32'h10FFFF || (u >= 32'hD800 && u <= 32'hDFFF))
              flag(unit_pos);
            else
              owe_code_point(u);
          end
        end
      end
      if (count != '1) count = count + 32'd1;
      if (last) begin
        if (odd)
          owe('0, utt8_pkg::ST_BAD, 1'b1, pos);
        else if (err_seen)
          owe('0, utt8_pkg::ST_BAD, 1'b1, err_pos);
        else
          owe('0, utt8_pkg::ST_OK, 1'b1, '0);
        clear_stream();
      end
    endfunction

    function void check_result(utf8_result_t act);
      utf8_result_t exp_r;
      if (utf8_due.size() == 0) begin
        $error("out_byte unexpected result: byte %0h status %0d", act.data, act.status);
        errors++;
        return;
      end
      exp_r = utf8_due.pop_front();
      if (act.data !== exp_r.data) begin
        $error("out_byte expected %0h got %0h", exp_r.data, act.data);
        errors++;
      end
      if (act.status !== exp_r.status) begin
        $error("out_status expected %0d got %0d", exp_r.status, act.status);
        errors++;
      end
      if (act.close !== exp_r.close) begin
        $error("out_last expected %0b got %0b", exp_r.close, act.close);
        errors++;
      end
      if (act.err_pos !== exp_r.err_pos) begin
        $error("out_error_pos expected %0h got %0h", exp_r.err_pos, act.err_pos);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        in_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic [1:0]  out_status_o;
  logic        out_last_o;
  logic [31:0] out_error_pos_o;

  transcode_tracker tracker = new();

  // Source bytes of the stream being assembled, and the format they are encoded in.
  logic [7:0] stream_q[$];
  logic [1:0] cur_fmt = utt8_pkg::FMT_U16LE;

  // Sender pacing: longest gap between bursts (0 = no gaps) and bytes left in the burst.
  int gap_max = 0;
  int burst_left = 0;
  int items_sent = 0;

  // Sink pacing: stall level (0 = never stall), current run and its remaining length.
  int stall_level = 0;
  int run_left = 0;
  bit stalled = 1'b0;

  utf16_utf32_to_utf8_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_status_o    (out_status_o),
    .out_last_o      (out_last_o),
    .out_error_pos_o (out_error_pos_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the sink in runs of random length; a run of stall alternates with a run of flow.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_level == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalled = !stalled;
          run_left = stalled ? $urandom_range(1, 2 * stall_level) : $urandom_range(1, 8);
        end
        run_left--;
        out_stall_i <= stalled;
      end
    end
  end

  // Check every transaction on the UTF-8 side against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result({out_byte_o, out_status_o, out_last_o, out_error_pos_o});
  end

  // Append one code unit to the stream in the current format and byte order.
  function automatic void push_unit(logic [31:0] u);
    case (cur_fmt)
      utt8_pkg::FMT_U16LE: begin
        stream_q.push_back(u[7:0]);
        stream_q.push_back(u[15:8]);
      end
      utt8_pkg::FMT_U16BE: begin
        stream_q.push_back(u[15:8]);
        stream_q.push_back(u[7:0]);
      end
      utt8_pkg::FMT_U32LE: begin
        stream_q.push_back(u[7:0]);
        stream_q.push_back(u[15:8]);
        stream_q.push_back(u[23:16]);
        stream_q.push_back(u[31:24]);
      end
      default: begin
        stream_q.push_back(u[31:24]);
        stream_q.push_back(u[23:16]);
        stream_q.push_back(u[15:8]);
        stream_q.push_back(u[7:0]);
      end
    endcase
  endfunction

  // Append a valid code point; split supplementary ones into a surrogate pair in UTF-16.
  function automatic void push_cp(logic [31:0] cp);
    logic [31:0] v;
    if (!cur_fmt[1] && cp >= 32'h10000) begin
      v = cp - 32'h10000;
      push_unit(32'hD800 | {22'h0, v[19:10]});
      push_unit(32'hDC00 | {22'h0, v[9:0]});
    end else begin
      push_unit(cp);
    end
  endfunction

  // Draw a scalar value from one of the four UTF-8 length classes.
  function automatic logic [31:0] rand_cp();
    logic [31:0] cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 32'hD800) cp = cp + 32'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  // Build one random stream: mostly well formed, some with a bad unit, a ragged
  // tail, or plain noise.
  function automatic void build_stream();
    int n;
    int kind;
    int err_at;
    int sub;
    bit hi_tail;
    n = $urandom_range(1, 6);
    kind = $urandom_range(0, 9);
    err_at = $urandom_range(0, n - 1);
    sub = $urandom_range(0, 2);
    hi_tail = 1'b0;
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (kind == 7 && i == err_at) begin
        if (!cur_fmt[1]) begin
          case (sub)
            0: push_unit(32'hDC00 | 32'($urandom_range(0, 'h3FF)));
            1: begin
              push_unit(32'hD800 | 32'($urandom_range(0, 'h3FF)));
              push_cp($urandom_range(0, 'hD7FF));
            end
            default: hi_tail = 1'b1;
          endcase
        end else if (sub == 0) begin
          push_unit($urandom_range('h110000, 'hFFFFFFFF));
        end else begin
          push_unit($urandom_range('hD800, 'hDFFF));
        end
      end
      push_cp(rand_cp());
    end
    // A high surrogate as the stream's final unit.
    if (hi_tail) push_unit(32'hD800 | 32'($urandom_range(0, 'h3FF)));
    // Odd UTF-16 length or a partial trailing UTF-32 unit.
    if (kind == 8 || (kind == 7 && $urandom_range(0, 3) == 0))
      repeat (cur_fmt[1] ? $urandom_range(1, 3) : 1)
        stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Offer one byte; hold it until the unit takes it, then let the tracker see it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    tracker.note_byte(b, last);
    items_sent++;
  endtask

  // Send the assembled stream; mark its final byte only when it is to be closed.
  task automatic send_stream(input bit close);
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], close && i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.utf8_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the format register, then read it back.
  task automatic write_format(input logic [1:0] f);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {utt8_pkg::REG_FORMAT, 2'b00};
    pwdata <= {30'd0, f};
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    tracker.set_format(f);
    cur_fmt = f;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (prdata !== {30'd0, f}) begin
      $error("prdata expected %0h got %0h", {30'd0, f}, prdata);
      tracker.errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int phase_bytes;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    in_last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting in the reset format (UTF-16 LE).
    stall_level = 1;
    // One code point of each UTF-8 length, including U+0000 and U+10FFFF.
    push_cp(32'h0);
    push_cp(32'h7FF);
    push_cp(32'hFFFF);
    push_cp(32'h10FFFF);
    send_stream(1'b1);
    // High surrogate then a stray byte: reported as odd length at the stray byte.
    push_unit(32'hD800);
    stream_q.push_back(8'h7F);
    send_stream(1'b1);
    drain();
    write_format(utt8_pkg::FMT_U16BE);
    // High surrogate followed by a plain unit: reported at the plain unit.
    push_unit(32'hDBFF);
    push_unit(32'h0041);
    send_stream(1'b1);
    // High surrogate as the last unit: reported at itself.
    push_unit(32'hD801);
    send_stream(1'b1);
    drain();
    write_format(utt8_pkg::FMT_U32LE);
    // Above U+10FFFF, then one trailing byte that must be ignored.
    push_unit(32'h110000);
    stream_q.push_back(8'h01);
    send_stream(1'b1);
    drain();
    write_format(utt8_pkg::FMT_U32BE);
    // UTF-32 value in the surrogate range.
    push_unit(32'hDFFF);
    send_stream(1'b1);
    drain();

    // Random phases: walk all formats first, then pick at random; vary pacing per phase.
    for (int ph = 0; items_sent < 410; ph++) begin
      case (ph)
        0: write_format(utt8_pkg::FMT_U16LE);
        1: write_format(utt8_pkg::FMT_U32BE);
        2: write_format(utt8_pkg::FMT_U16BE);
        3: write_format(utt8_pkg::FMT_U32LE);
        default: write_format(2'($urandom_range(utt8_pkg::FMT_U16LE, utt8_pkg::FMT_U32BE)));
      endcase
      gap_max = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 2 : 6);
      stall_level = (ph % 4 == 0) ? 0 : (ph % 4 == 1 ? 1 : 3);
      burst_left = 0;
      phase_bytes = items_sent;
      while (items_sent - phase_bytes < 45 && items_sent < 410) begin
        build_stream();
        send_stream(1'b1);
      end
      // Leave a stream open now and then; the next format write must abort it.
      if ($urandom_range(0, 1) == 1) begin
        build_stream();
        send_stream(1'b0);
      end
      drain();
    end

    drain();
    stall_level = 0;
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.utf8_due.size() == 0) begin
      $display("[utf16_utf32_to_utf8_unit] OK");
    end else begin
      $display("[utf16_utf32_to_utf8_unit] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2000000;
    $display("[utf16_utf32_to_utf8_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/utt8_pkg.sv
src/utt8_front.sv
src/utt8_queue.sv
src/utt8_back.sv
src/utf16_utf32_to_utf8_unit.sv
bench/utf16_utf32_to_utf8_unit_tb.sv
